### hdl/substring_find_with_match_flags_defines.svh
// assertion helpers used by the top-level rtl file
`ifndef SUBSTRING_FIND_WITH_MATCH_FLAGS_DEFINES_SVH
`define SUBSTRING_FIND_WITH_MATCH_FLAGS_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SFM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SFM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sfm_pkg.sv
package sfm_pkg;

    localparam int unsigned NEEDLE_REG_BYTES   = 16;
    localparam int unsigned MAX_NEEDLE_DEFAULT = 16;
    localparam int unsigned NIDX_W             = $clog2(NEEDLE_REG_BYTES);
    localparam int unsigned LEN_W              = 5;
    localparam int unsigned POS_W              = 32;
    localparam int unsigned CFG_DATA_W         = 64;
    localparam int unsigned CFG_ADDR_W         = 6;
    localparam int unsigned CFG_IDX_W          = 3;

    localparam logic [7:0] ASCII_UPPER_A = 8'd65;
    localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
    localparam logic [7:0] ASCII_CASE_OFS = 8'd32;
    localparam logic [7:0] ASCII_SLASH = 8'h2f;
    localparam logic [7:0] ASCII_BACKSLASH = 8'h5c;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEEDLE_LOW  = 3'd0,
        REG_NEEDLE_HIGH = 3'd1,
        REG_NEEDLE_LEN  = 3'd2,
        REG_START_POS   = 3'd3,
        REG_CASE_INS    = 3'd4,
        REG_SLASH_INS   = 3'd5
    } sfm_reg_idx_t;

    typedef struct packed {
        logic [NEEDLE_REG_BYTES-1:0][7:0] needle;
        logic [LEN_W-1:0]                 needle_length;
        logic [POS_W-1:0]                 start_position;
        logic                             case_insensitive;
        logic                             slash_insensitive;
    } sfm_cfg_t;

endpackage

### hdl/sfm_text_if.sv
interface sfm_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

### hdl/sfm_result_if.sv
interface sfm_result_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [sfm_pkg::POS_W-1:0]  match_position;

    modport source (output valid, output found, output match_position, input ready);
    modport sink (input valid, input found, input match_position, output ready);
endinterface

### hdl/sfm_cfg_regs.sv
module sfm_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sfm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sfm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output sfm_pkg::sfm_cfg_t              cfg
);
    import sfm_pkg::*;

    sfm_cfg_t     cfg_reg;
    sfm_cfg_t     cfg_next;
    sfm_reg_idx_t reg_idx;
    logic         wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = sfm_reg_idx_t'(paddr[CFG_ADDR_W-1:CFG_ADDR_W-CFG_IDX_W]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_NEEDLE_LOW:  cfg_next.needle[7:0] = pwdata;
                REG_NEEDLE_HIGH: cfg_next.needle[15:8] = pwdata;
                REG_NEEDLE_LEN:  cfg_next.needle_length = pwdata[LEN_W-1:0];
                REG_START_POS:   cfg_next.start_position = pwdata[POS_W-1:0];
                REG_CASE_INS:    cfg_next.case_insensitive = pwdata[0];
                REG_SLASH_INS:   cfg_next.slash_insensitive = pwdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_NEEDLE_LOW:  prdata = cfg_reg.needle[7:0];
            REG_NEEDLE_HIGH: prdata = cfg_reg.needle[15:8];
            REG_NEEDLE_LEN:  prdata = CFG_DATA_W'(cfg_reg.needle_length);
            REG_START_POS:   prdata = CFG_DATA_W'(cfg_reg.start_position);
            REG_CASE_INS:    prdata = CFG_DATA_W'(cfg_reg.case_insensitive);
            REG_SLASH_INS:   prdata = CFG_DATA_W'(cfg_reg.slash_insensitive);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/sfm_cell.sv
module sfm_cell (
    input  logic       clk,
    input  logic       shift_en,
    input  logic [7:0] byte_in,
    input  logic [7:0] needle_byte,
    input  logic       case_insensitive,
    input  logic       slash_insensitive,
    output logic [7:0] byte_out,
    output logic       agree
);
    import sfm_pkg::*;

    logic [7:0] byte_reg;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) ? c + ASCII_CASE_OFS : c;
    endfunction

    function automatic logic [7:0] fold_slash(input logic [7:0] c);
        return (c == ASCII_BACKSLASH) ? ASCII_SLASH : c;
    endfunction

    // each rule is checked on its own, any enabled rule accepts the pair
    assign agree = (byte_in == needle_byte)
                || (case_insensitive && (fold_case(byte_in) == fold_case(needle_byte)))
                || (slash_insensitive && (fold_slash(byte_in) == fold_slash(needle_byte)));

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

endmodule

### hdl/substring_find_with_match_flags.sv
// streaming substring search with case and slash folding
// text_in carries haystack bytes, one request per byte, last_byte marks the end;
// result_out carries one request per haystack: found and the first match position
// (position is zero when nothing matched)
// the needle, its length, the start position and the two folding flags are set
// through the apb port by the user while no haystack is in flight (not enforced)
// a byte is taken every cycle while no result is stalled: a row of compare cells
// holds the most recent bytes, shifts once per accepted byte and checks the whole
// window against the needle in the same cycle, so throughput is one byte per clock
// the result appears in the cycle after the last byte is accepted and sits in an
// output register; while it is not taken, text_in.ready stays low and no byte
// is accepted, so with the receiver ready haystacks stream back to back and
// a stalled receiver holds off the input while a result is posted
// reset clears the byte count, the match state, the pending result flag and all
// configuration registers; no clearing pass is needed
// the byte count saturates at its maximum, later bytes share that position
module substring_find_with_match_flags #(
    parameter int unsigned MAX_NEEDLE = sfm_pkg::MAX_NEEDLE_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sfm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sfm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    sfm_text_if.sink                       text_in,
    sfm_result_if.source                   result_out
);
    `include "substring_find_with_match_flags_defines.svh"
    import sfm_pkg::*;

    localparam int unsigned NCELL =
        (MAX_NEEDLE < NEEDLE_REG_BYTES) ? MAX_NEEDLE : NEEDLE_REG_BYTES;
    localparam logic [LEN_W-1:0] NCELL_LEN = LEN_W'(NCELL);

    sfm_cfg_t cfg;

    logic [LEN_W-1:0] len_eff;
    logic             in_fire;
    logic [7:0]       chain_in [NCELL];
    logic [NCELL-1:0] active;
    logic [NCELL-1:0] agree;
    logic             window_agree;

    logic [POS_W-1:0] bytes_seen_reg;
    logic [POS_W-1:0] bytes_seen_next;
    logic             have_match_reg;
    logic             have_match_next;
    logic [POS_W-1:0] first_pos_reg;
    logic [POS_W-1:0] first_pos_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_found_reg;
    logic             out_found_next;
    logic [POS_W-1:0] out_pos_reg;
    logic [POS_W-1:0] out_pos_next;

    logic [POS_W:0]   pos_plus1;
    logic [POS_W:0]   len_wide;
    logic [POS_W:0]   start_plus_len;
    logic [POS_W-1:0] window_start;
    logic             match_now;

    sfm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign len_eff = (cfg.needle_length > NCELL_LEN) ? NCELL_LEN : cfg.needle_length;

    assign text_in.ready = !out_valid_reg || result_out.ready;
    assign in_fire       = text_in.valid && text_in.ready;

    assign chain_in[0] = text_in.text_byte;

    // cell w sees the byte w places back and checks it against needle byte len-1-w
    for (genvar w = 0; w < NCELL; w++)
    begin : g_cell
        logic [LEN_W-1:0] tap;
        logic [7:0]       needle_byte;

        assign tap         = len_eff - LEN_W'(w) - LEN_W'(1);
        assign needle_byte = cfg.needle[tap[NIDX_W-1:0]];
        assign active[w]   = LEN_W'(w) < len_eff;

        if (w < NCELL - 1)
        begin : g_link
            sfm_cell u_cell (
                .clk               (clk),
                .shift_en          (in_fire),
                .byte_in           (chain_in[w]),
                .needle_byte       (needle_byte),
                .case_insensitive  (cfg.case_insensitive),
                .slash_insensitive (cfg.slash_insensitive),
                .byte_out          (chain_in[w+1]),
                .agree             (agree[w])
            );
        end
        else
        begin : g_tail
            sfm_cell u_cell (
                .clk               (clk),
                .shift_en          (in_fire),
                .byte_in           (chain_in[w]),
                .needle_byte       (needle_byte),
                .case_insensitive  (cfg.case_insensitive),
                .slash_insensitive (cfg.slash_insensitive),
                .byte_out          (),
                .agree             (agree[w])
            );
        end
    end

    assign window_agree = &(~active | agree);

    // window start = pos + 1 - len, checked without underflow in one extra bit
    assign pos_plus1      = {1'b0, bytes_seen_reg} + (POS_W+1)'(1);
    assign len_wide       = (POS_W+1)'(len_eff);
    assign start_plus_len = {1'b0, cfg.start_position} + len_wide;
    assign window_start   = POS_W'(pos_plus1 - len_wide);

    always_comb
    begin
        if (len_eff == '0)
        begin
            match_now = (bytes_seen_reg == cfg.start_position);
        end
        else
        begin
            match_now = window_agree && (pos_plus1 >= len_wide)
                     && (pos_plus1 >= start_plus_len);
        end
    end

    always_comb
    begin
        bytes_seen_next = bytes_seen_reg;
        have_match_next = have_match_reg;
        first_pos_next  = first_pos_reg;
        out_valid_next  = out_valid_reg;
        out_found_next  = out_found_reg;
        out_pos_next    = out_pos_reg;

        if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_fire)
        begin
            if (!have_match_reg && match_now)
            begin
                have_match_next = 1'b1;
                first_pos_next  = (len_eff == '0) ? bytes_seen_reg : window_start;
            end
            if (bytes_seen_reg != '1)
            begin
                bytes_seen_next = bytes_seen_reg + POS_W'(1);
            end

            if (text_in.last_byte)
            begin
                out_valid_next  = 1'b1;
                out_found_next  = have_match_next;
                out_pos_next    = have_match_next ? first_pos_next : '0;
                bytes_seen_next = '0;
                have_match_next = 1'b0;
                first_pos_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg <= '0;
            have_match_reg <= 1'b0;
            first_pos_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            bytes_seen_reg <= bytes_seen_next;
            have_match_reg <= have_match_next;
            first_pos_reg  <= first_pos_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_found_reg <= out_found_next;
        out_pos_reg   <= out_pos_next;
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.found          = out_found_reg;
    assign result_out.match_position = out_pos_reg;

    `SFM_ASSERT_NXT(a_last_clears, in_fire && text_in.last_byte,
        out_valid_reg && !have_match_reg && (bytes_seen_reg == '0),
        "last byte did not post a result and clear the haystack state")
    `SFM_ASSERT_IMP(a_miss_pos_zero, out_valid_reg && !out_found_reg,
        out_pos_reg == '0, "miss result carries a nonzero position")
    `SFM_ASSERT_IMP(a_match_not_ahead, have_match_reg,
        first_pos_reg <= bytes_seen_reg, "match position lies past the bytes seen")

endmodule
